// ===== src/dssf_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter package
// Shared types, constants and the digit and glyph helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dssf_pkg;

  localparam int ValueWidth   = 16;
  localparam int NumWidth     = 14;
  localparam int DigitWidth   = 4;
  localparam int AddrWidth    = 3;
  localparam int SegWidth     = 8;
  localparam int BeatCntWidth = 2;

  localparam logic [ValueWidth-1:0] SatLimit    = 16'd9999;
  localparam logic [SegWidth-1:0]   DegreeGlyph = 8'h63;

  localparam logic [NumWidth-1:0] WeightThousands = 14'd1000;
  localparam logic [NumWidth-1:0] WeightHundreds  = 14'd100;
  localparam logic [NumWidth-1:0] WeightTens      = 14'd10;

  localparam logic [AddrWidth-1:0] AddrFirst  = 3'd3;
  localparam logic [AddrWidth-1:0] AddrSecond = 3'd2;
  localparam logic [AddrWidth-1:0] AddrThird  = 3'd1;
  localparam logic [AddrWidth-1:0] AddrLast   = 3'd4;

  localparam logic [BeatCntWidth-1:0] BeatFirst  = 2'd0;
  localparam logic [BeatCntWidth-1:0] BeatSecond = 2'd1;
  localparam logic [BeatCntWidth-1:0] BeatThird  = 2'd2;
  localparam logic [BeatCntWidth-1:0] BeatLast   = 2'd3;

  localparam logic ModeInteger     = 1'b0;
  localparam logic ModeTemperature = 1'b1;

  typedef struct packed {
    logic [DigitWidth-1:0] digit;
    logic [NumWidth-1:0]   rem;
  } split_t;

  typedef struct packed {
    logic [DigitWidth-1:0] thousands;
    logic [DigitWidth-1:0] hundreds;
    logic [DigitWidth-1:0] tens;
    logic [DigitWidth-1:0] units;
  } digits_t;

  // One decimal digit from a value below ten times the weight.
  function automatic split_t digit_split(input logic [NumWidth-1:0] n,
                                         input logic [NumWidth-1:0] weight);
    split_t                res;
    logic   [NumWidth-1:0] thr;
    res.digit = '0;
    res.rem   = n;
    for (int k = 1; k < 10; k++) begin
      thr = NumWidth'(k) * weight;
      if (n >= thr) begin
        res.digit = DigitWidth'(k);
        res.rem   = n - thr;
      end
    end
    return res;
  endfunction

  function automatic logic [SegWidth-1:0] digit_glyph(input logic [DigitWidth-1:0] d);
    logic [SegWidth-1:0] g;
    unique case (d)
      4'd0:    g = 8'h7E;
      4'd1:    g = 8'h30;
      4'd2:    g = 8'h6D;
      4'd3:    g = 8'h79;
      4'd4:    g = 8'h33;
      4'd5:    g = 8'h5B;
      4'd6:    g = 8'h5F;
      4'd7:    g = 8'h70;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h7B;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== src/dssf_serializer.sv =====
// ----------------------------------------------------------------------------
// Display write serializer
// Holds one set of digits and sends it as four display-register write beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssf_serializer
  import dssf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire digits_t              load_digits,
  input  wire logic                 mode,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [AddrWidth-1:0]      digit_address,
  output logic [SegWidth-1:0]       segment_byte,
  output logic                      last_write
);

  logic                    busy;
  logic [BeatCntWidth-1:0] beat;
  digits_t                 digits;
  logic                    done;
  logic [DigitWidth-1:0]   shown;

  assign done = out_ready && (beat == BeatLast);
  assign free = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= BeatFirst;
    end else if (load && free) begin
      busy <= 1'b1;
      beat <= BeatFirst;
    end else if (busy && out_ready) begin
      if (beat == BeatLast) begin
        busy <= 1'b0;
      end
      beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      digits <= load_digits;
    end
  end

  always_comb begin
    unique case (beat)
      BeatFirst: begin
        digit_address = AddrFirst;
        shown         = (mode == ModeInteger) ? digits.thousands : digits.hundreds;
      end
      BeatSecond: begin
        digit_address = AddrSecond;
        shown         = (mode == ModeInteger) ? digits.hundreds : digits.tens;
      end
      BeatThird: begin
        digit_address = AddrThird;
        shown         = (mode == ModeInteger) ? digits.tens : digits.units;
      end
      default: begin
        digit_address = AddrLast;
        shown         = digits.units;
      end
    endcase
  end

  assign segment_byte = ((beat == BeatLast) && (mode == ModeTemperature)) ?
                        DegreeGlyph : digit_glyph(shown);
  assign last_write   = (beat == BeatLast);
  assign out_valid    = busy;

endmodule

`default_nettype wire

// ===== src/decimal_seven_segment_formatter_top.sv =====
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter
// Turns a 16-bit unsigned value into four seven-segment display writes.
//
// The input channel (value, in_valid, in_ready) takes one value per beat.
// The value is saturated at 9999 and split into decimal digits in a
// four-stage pipeline: saturation, thousands, hundreds, then tens and units.
// Each stage carries its own valid bit and holds its item while the next
// stage is full, so a stall never drops or repeats an item.
// The output channel (digit_address, segment_byte, last_write, out_valid,
// out_ready) gives four write beats per value; last_write marks the fourth.
// The serializer loads new digits as its last beat is taken; the first beat
// of a value follows the pipeline stages and the serializer load.
// The configuration channel (display_mode, cfg_valid, cfg_ready) is always
// ready; it selects integer or temperature layout and must only be written
// while no value is in flight.
// Reset empties the pipeline and the serializer and sets integer mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module decimal_seven_segment_formatter_top
  import dssf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [ValueWidth-1:0] value,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  display_mode,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  output logic [AddrWidth-1:0]       digit_address,
  output logic [SegWidth-1:0]        segment_byte,
  output logic                       last_write,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  logic                  mode;
  logic                  v1, v2, v3, v4;
  logic                  r1, r2, r3, r4;
  logic                  ser_free;
  logic [NumWidth-1:0]   n1, n2, n3;
  logic [DigitWidth-1:0] th2, th3, th4;
  logic [DigitWidth-1:0] hu3, hu4;
  logic [DigitWidth-1:0] te4, un4;
  split_t                sp_th, sp_hu, sp_te;
  digits_t               digits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeInteger;
    end else if (cfg_valid) begin
      mode <= display_mode;
    end
  end

  assign r4       = !v4 || ser_free;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  assign sp_th = digit_split(n1, WeightThousands);
  assign sp_hu = digit_split(n2, WeightHundreds);
  assign sp_te = digit_split(n3, WeightTens);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      n1 <= (value > SatLimit) ? NumWidth'(SatLimit) : value[NumWidth-1:0];
    end
    if (r2) begin
      n2  <= sp_th.rem;
      th2 <= sp_th.digit;
    end
    if (r3) begin
      n3  <= sp_hu.rem;
      th3 <= th2;
      hu3 <= sp_hu.digit;
    end
    if (r4) begin
      th4 <= th3;
      hu4 <= hu3;
      te4 <= sp_te.digit;
      un4 <= sp_te.rem[DigitWidth-1:0];
    end
  end

  assign digits = '{thousands: th4, hundreds: hu4, tens: te4, units: un4};

  dssf_serializer u_serializer (
    .clk           (clk),
    .rst           (rst),
    .load          (v4),
    .load_digits   (digits),
    .mode          (mode),
    .free          (ser_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_address (digit_address),
    .segment_byte  (segment_byte),
    .last_write    (last_write)
  );

endmodule

`default_nettype wire

// ===== tb/decimal_seven_segment_formatter_top_tb.sv =====
// ----------------------------------------------------------------------------
// Decimal seven-segment formatter testbench
// Drives values into the formatter in both display layouts and checks every
// display write beat against a local model of the digit split and glyph table.
// Covers the edges of the value range, saturation above 9999, random traffic
// under several idle and stall mixes, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_seven_segment_formatter_top_tb;
  import dssf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxReports = 10;

  localparam logic [SegWidth-1:0] Glyphs [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  typedef struct packed {
    logic [AddrWidth-1:0] addr;
    logic [SegWidth-1:0]  seg;
    logic                 last;
  } disp_write_t;

  typedef disp_write_t value_writes_t [4];

  logic                  clk;
  logic                  rst;
  logic [ValueWidth-1:0] value;
  logic                  in_valid;
  logic                  in_ready;
  logic                  display_mode;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [AddrWidth-1:0]  digit_address;
  logic [SegWidth-1:0]   segment_byte;
  logic                  last_write;
  logic                  out_valid;
  logic                  out_ready;

  disp_write_t pending_writes [$];
  logic        layout_mode;
  int          mismatch_count;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_len;
  logic        hold_go;

  decimal_seven_segment_formatter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .display_mode  (display_mode),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .digit_address (digit_address),
    .segment_byte  (segment_byte),
    .last_write    (last_write),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  function automatic value_writes_t format_value(logic [ValueWidth-1:0] v, logic mode);
    value_writes_t w;
    int            n;
    n = v;
    if (n > SatLimit) begin
      n = SatLimit;
    end
    if (mode == ModeInteger) begin
      w[0] = '{AddrFirst, Glyphs[n / 1000], 1'b0};
      w[1] = '{AddrSecond, Glyphs[(n / 100) % 10], 1'b0};
      w[2] = '{AddrThird, Glyphs[(n / 10) % 10], 1'b0};
      w[3] = '{AddrLast, Glyphs[n % 10], 1'b1};
    end else begin
      w[0] = '{AddrFirst, Glyphs[(n / 100) % 10], 1'b0};
      w[1] = '{AddrSecond, Glyphs[(n / 10) % 10], 1'b0};
      w[2] = '{AddrThird, Glyphs[n % 10], 1'b0};
      w[3] = '{AddrLast, DegreeGlyph, 1'b1};
    end
    return w;
  endfunction

  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] v;
    case ($urandom_range(3))
      0: v = ValueWidth'($urandom_range(65535));
      1: v = ValueWidth'($urandom_range(9999));
      2: v = ValueWidth'($urandom_range(10010, 9990));
      default: v = ValueWidth'($urandom_range(999));
    endcase
    return v;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("Mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    value_writes_t w;
    disp_write_t   exp_w;
    if (rst) begin
      layout_mode = ModeInteger;
      pending_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        layout_mode = display_mode;
      end
      if (in_valid && in_ready) begin
        w = format_value(value, layout_mode);
        for (int i = 0; i < 4; i++) begin
          pending_writes.push_back(w[i]);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          note_mismatch($sformatf("beat with nothing pending: addr %0d seg %h last %b",
                                  digit_address, segment_byte, last_write));
        end else begin
          exp_w = pending_writes.pop_front();
          if (digit_address !== exp_w.addr || segment_byte !== exp_w.seg ||
              last_write !== exp_w.last) begin
            note_mismatch($sformatf("expected addr %0d seg %h last %b, got addr %0d seg %h last %b",
                                    exp_w.addr, exp_w.seg, exp_w.last,
                                    digit_address, segment_byte, last_write));
          end
        end
      end
    end
  end

  task automatic send_value(logic [ValueWidth-1:0] v);
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    wait_drain();
    display_mode <= m;
    cfg_valid    <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_integer_edges();
    logic [ValueWidth-1:0] vals [17] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd1234,
      16'd5678, 16'd9012, 16'd3456, 16'd9998, 16'd9999, 16'd10000, 16'hFFFF, 16'hAAAA
    };
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
  endtask

  task automatic test_temperature_edges();
    logic [ValueWidth-1:0] vals [8] = '{
      16'd0, 16'd25, 16'd100, 16'd789, 16'd1000, 16'd9999, 16'd10000, 16'h5555
    };
    write_mode(ModeTemperature);
    foreach (vals[i]) begin
      send_value(vals[i]);
    end
    write_mode(ModeInteger);
  endtask

  task automatic test_random_phases();
    int tx_mix [4] = '{0, 75, 0, 26};
    int rx_mix [4] = '{0, 0, 75, 26};
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        write_mode(m[0]);
        tx_idle_pct  = tx_mix[p];
        rx_stall_pct = rx_mix[p];
        repeat (27) send_value(random_value());
      end
    end
  endtask

  task automatic test_output_hold_off();
    write_mode(ModeInteger);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_len     = 300;
    hold_go      = ~hold_go;
    repeat (24) send_value(random_value());
    wait_drain();
  endtask

  task automatic test_drain_pause();
    write_mode(ModeTemperature);
    tx_idle_pct  = 26;
    rx_stall_pct = 26;
    repeat (8) send_value(random_value());
    wait_drain();
    repeat (8) send_value(random_value());
    wait_drain();
  endtask

  initial begin
    rst            = 1'b1;
    value          = '0;
    in_valid       = 1'b0;
    display_mode   = ModeInteger;
    cfg_valid      = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_len       = 0;
    hold_go        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_integer_edges();
    test_temperature_edges();
    test_random_phases();
    test_output_hold_off();
    test_drain_pause();
    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
